// File: hdl/bha_pkg.sv
// shared types, constants and helper functions of the binned heap allocator
package bha_pkg;

  localparam int ARITH_W   = 20;
  localparam int LINK_W    = 16;
  localparam int DATA_W    = 32;
  localparam int BIN_IDX_W = 6;
  localparam int LIMIT_W   = 17;

  localparam int DEF_HEAP_BYTES = 65536;
  localparam int DEF_NUM_BINS   = 17;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam int ADDR_SPAN    = 65536;
  localparam int TAG_OVERHEAD = 16;

  localparam logic [DATA_W-1:0]  USED_MARK   = 32'hDEAD_DEAD;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h1_0000;

  typedef logic [ARITH_W-1:0] addr_t;

  // one access to the tag store
  typedef struct packed {
    logic              en;
    logic              we;
    addr_t             addr;
    logic [DATA_W-1:0] wdata;
  } tag_cmd_t;

  // one write to the bin head table
  typedef struct packed {
    logic                 we;
    logic [BIN_IDX_W-1:0] idx;
    logic [LINK_W-1:0]    val;
  } bin_cmd_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7,
    S_AM0, S_AM1,
    S_G0, S_G1, S_G2, S_G3,
    S_F0, S_F1, S_F2, S_F3, S_F4,
    S_FL1, S_FL2, S_FL3, S_FL4, S_FL5,
    S_FR0, S_FR1, S_FR2, S_FR3, S_FR4,
    S_FIN,
    S_UL0, S_UL1, S_UL2,
    S_SP0, S_SP1,
    S_IN0, S_IN1,
    S_RESULT
  } seq_state_t;

  // index of the highest set bit, zero for values below two
  function automatic logic [BIN_IDX_W:0] msb_index(addr_t v);
    logic [BIN_IDX_W:0] r;
    r = '0;
    for (int i = 1; i < ARITH_W; i++) begin
      if (v[i]) r = (BIN_IDX_W+1)'(i);
    end
    return r;
  endfunction

  function automatic addr_t chunk_of(logic [DATA_W-1:0] l);
    return addr_t'({l[LINK_W-1:3], 3'b000});
  endfunction

  function automatic logic [LINK_W-1:0] link_of(addr_t c);
    return {c[LINK_W-1:3], 3'b001};
  endfunction

  function automatic logic size_ok(logic [DATA_W-1:0] s, addr_t room);
    return (s >= DATA_W'(TAG_OVERHEAD)) && (s[2:0] == 3'b000) && (s <= DATA_W'(room));
  endfunction

endpackage

// File: hdl/bha_tag_mem.sv
// single-port tag store, one access a cycle, registered read data
module bha_tag_mem #(
  parameter int HEAP_BYTES = bha_pkg::DEF_HEAP_BYTES
) (
  input  logic                       clk,
  input  bha_pkg::tag_cmd_t          cmd,
  output logic [bha_pkg::DATA_W-1:0] rdata
);
  import bha_pkg::*;

  localparam int WORDS = (HEAP_BYTES / 4 < 2 ** (ARITH_W - 2)) ?
                         HEAP_BYTES / 4 : 2 ** (ARITH_W - 2);
  localparam int IDX_W = $clog2(WORDS);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rdata_q;
  logic              rd_ok;
  logic              in_range;
  logic [IDX_W-1:0]  idx;

  // words past the arena read as zero and drop writes
  assign in_range = 32'(cmd.addr[ARITH_W-1:2]) < 32'(WORDS);
  assign idx      = cmd.addr[IDX_W+1:2];

  always_ff @(posedge clk) begin
    if (cmd.en && cmd.we && in_range) begin
      mem[idx] <= cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && !cmd.we) begin
      rdata_q <= mem[idx];
      rd_ok   <= in_range;
    end
  end

  assign rdata = rd_ok ? rdata_q : '0;

endmodule

// File: hdl/bha_bins.sv
// bin head table, occupancy bitmap and lowest usable bin search
module bha_bins #(
  parameter int NUM_BINS = bha_pkg::DEF_NUM_BINS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bha_pkg::bin_cmd_t             cmd,
  input  logic [bha_pkg::BIN_IDX_W-1:0] head_idx,
  output logic [bha_pkg::LINK_W-1:0]    head,
  input  logic [bha_pkg::BIN_IDX_W:0]   min_bin,
  output logic                          avail_any,
  output logic [bha_pkg::BIN_IDX_W-1:0] avail_idx
);
  import bha_pkg::*;

  localparam int BIN_W = $clog2(NUM_BINS);

  logic [LINK_W-1:0]   heads [NUM_BINS];
  logic [NUM_BINS-1:0] bitmap;
  logic [NUM_BINS-1:0] avail;
  logic [NUM_BINS-1:0] live;

  // head update keeps the bitmap bit in step
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) heads[i] <= '0;
      bitmap <= '0;
    end else if (cmd.we) begin
      heads[cmd.idx[BIN_W-1:0]]  <= cmd.val;
      bitmap[cmd.idx[BIN_W-1:0]] <= (cmd.val != '0);
    end
  end

  assign head = heads[head_idx[BIN_W-1:0]];

  // lowest non-empty bin at or above the minimum
  always_comb begin
    avail_idx = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      avail[i] = bitmap[i] && ((BIN_IDX_W+1)'(i) >= min_bin);
      live[i]  = (heads[i] != '0);
    end
    for (int i = NUM_BINS - 1; i >= 0; i--) begin
      if (avail[i]) avail_idx = BIN_IDX_W'(i);
    end
  end

  assign avail_any = (avail != '0);

  a_bitmap_tracks_heads: assert property (@(posedge clk) disable iff (rst)
    bitmap == live) else $error("bin bitmap out of step with bin heads");

endmodule

// File: hdl/bha_seq.sv
// request sequencer: walks tags and links through the tag store
module bha_seq #(
  parameter int HEAP_BYTES = bha_pkg::DEF_HEAP_BYTES,
  parameter int NUM_BINS   = bha_pkg::DEF_NUM_BINS,
  parameter int PAGE_BYTES = bha_pkg::DEF_PAGE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          op,
  input  logic [15:0]                   request_size,
  input  logic [15:0]                   payload_offset,
  input  logic [bha_pkg::LIMIT_W-1:0]   heap_limit,
  input  logic                          out_free,
  output logic                          busy,
  output logic                          done,
  output logic [15:0]                   res_offset,
  output logic                          res_status,
  output bha_pkg::tag_cmd_t             tag_cmd,
  input  logic [bha_pkg::DATA_W-1:0]    tag_rdata,
  output bha_pkg::bin_cmd_t             bin_cmd,
  output logic [bha_pkg::BIN_IDX_W-1:0] head_idx,
  input  logic [bha_pkg::LINK_W-1:0]    head,
  output logic [bha_pkg::BIN_IDX_W:0]   min_bin,
  input  logic                          avail_any,
  input  logic [bha_pkg::BIN_IDX_W-1:0] avail_idx
);
  import bha_pkg::*;

  localparam addr_t PAGE_MASK = addr_t'(PAGE_BYTES - 1);

  seq_state_t state, state_next, ret, ret_next;

  logic [15:0]          p_q;
  addr_t                sz, c, s, aux, ax, asz, sp_chunk;
  addr_t                used, spare, top;
  logic [LINK_W-1:0]    prv, sp_val;
  logic [BIN_IDX_W-1:0] bi;

  addr_t             cs, left, csz, grow_need, f0_c;
  logic [DATA_W-1:0] binsize;
  logic              split, grow_fail, f0_bad, fin_tail;
  logic              rd_used, rd_zero;

  function automatic logic [BIN_IDX_W-1:0] bin_of(addr_t v);
    logic [BIN_IDX_W:0] m;
    m = msb_index(v);
    return (m >= (BIN_IDX_W+1)'(NUM_BINS)) ? BIN_IDX_W'(NUM_BINS - 1) : m[BIN_IDX_W-1:0];
  endfunction

  // shared conditions
  assign cs        = c + s;
  assign binsize   = DATA_W'(1) << bi;
  assign split     = (binsize >= DATA_W'(sz)) &&
                     ((binsize - DATA_W'(sz)) >= DATA_W'(TAG_OVERHEAD));
  assign left      = addr_t'(binsize - DATA_W'(sz));
  assign csz       = addr_t'(tag_rdata - (binsize - DATA_W'(sz)));
  assign grow_need = ((sz - spare) + PAGE_MASK) & ~PAGE_MASK;
  assign grow_fail = ((used + spare + aux) >= addr_t'(heap_limit)) ||
                     (DATA_W'(top + aux) > DATA_W'(HEAP_BYTES)) ||
                     (DATA_W'(top + aux) > DATA_W'(ADDR_SPAN));
  assign f0_c      = addr_t'(p_q) - addr_t'(8);
  assign f0_bad    = (p_q == '0) || (p_q[2:0] != 3'b000) || (f0_c >= used);
  assign fin_tail  = (cs >= used);
  assign rd_used   = (tag_rdata == USED_MARK);
  assign rd_zero   = (tag_rdata == '0);

  assign busy     = (state != S_IDLE);
  assign head_idx = bi;
  assign min_bin  = msb_index(sz - addr_t'(1)) + (BIN_IDX_W+1)'(1);

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      S_IDLE:   if (start) state_next = op ? S_F0 : S_A0;
      S_A0:     state_next = avail_any ? S_A1 : S_G0;
      S_A1:     state_next = S_A2;
      S_A2: begin
        if (!rd_zero) begin
          ret_next   = S_A3;
          state_next = S_SP0;
        end else begin
          state_next = S_A3;
        end
      end
      S_A3:     state_next = S_A4;
      S_A4:     state_next = split ? S_A5 : S_AM0;
      S_A5:     state_next = S_A6;
      S_A6:     state_next = S_A7;
      S_A7: begin
        ret_next   = S_AM0;
        state_next = S_IN0;
      end
      S_AM0:    state_next = S_AM1;
      S_AM1:    state_next = S_RESULT;
      S_G0:     state_next = (spare < sz) ? S_G1 : S_G2;
      S_G1:     state_next = grow_fail ? S_RESULT : S_G2;
      S_G2:     state_next = S_G3;
      S_G3:     state_next = S_AM0;
      S_F0:     state_next = f0_bad ? S_RESULT : S_F1;
      S_F1:     state_next = size_ok(tag_rdata, used - c) ? S_F2 : S_RESULT;
      S_F2:     state_next = rd_used ? S_F3 : S_RESULT;
      S_F3:     state_next = rd_used ? S_F4 : S_RESULT;
      S_F4: begin
        if (tag_rdata != DATA_W'(s)) state_next = S_RESULT;
        else if (c != '0)           state_next = S_FL1;
        else                        state_next = S_FR0;
      end
      S_FL1:    state_next = size_ok(tag_rdata, c) ? S_FL2 : S_FR0;
      S_FL2:    state_next = (tag_rdata == DATA_W'(aux)) ? S_FL3 : S_FR0;
      S_FL3: begin
        if (!rd_used) begin
          ret_next   = S_FL4;
          state_next = S_UL0;
        end else begin
          state_next = S_FR0;
        end
      end
      S_FL4:    state_next = S_FL5;
      S_FL5:    state_next = S_FR0;
      S_FR0:    state_next = (cs < used) ? S_FR1 : S_FIN;
      S_FR1:    state_next = size_ok(tag_rdata, used - cs) ? S_FR2 : S_FIN;
      S_FR2: begin
        if (!rd_used) begin
          ret_next   = S_FR3;
          state_next = S_UL0;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FR3:    state_next = S_FR4;
      S_FR4:    state_next = S_FIN;
      S_FIN: begin
        if (fin_tail) begin
          state_next = S_RESULT;
        end else begin
          ret_next   = S_RESULT;
          state_next = S_IN0;
        end
      end
      S_UL0:    state_next = S_UL1;
      S_UL1:    state_next = S_UL2;
      S_UL2:    state_next = rd_zero ? ret : S_SP0;
      S_SP0:    state_next = S_SP1;
      S_SP1:    state_next = ret;
      S_IN0:    state_next = S_IN1;
      S_IN1:    state_next = (head != '0) ? S_SP0 : ret;
      S_RESULT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // tag store and bin table commands
  always_comb begin
    tag_cmd = '0;
    bin_cmd = '0;
    done    = 1'b0;
    case (state)
      S_A1: tag_cmd = '{1'b1, 1'b0, chunk_of(DATA_W'(head)) + addr_t'(4), '0};
      S_A2: bin_cmd = '{1'b1, bi, tag_rdata[LINK_W-1:0]};
      S_A3: tag_cmd = '{1'b1, 1'b0, c, '0};
      S_A4: if (split) tag_cmd = '{1'b1, 1'b1, c, DATA_W'(csz)};
      S_A5: tag_cmd = '{1'b1, 1'b1, cs - addr_t'(4), DATA_W'(s)};
      S_A6: tag_cmd = '{1'b1, 1'b1, cs, DATA_W'(aux)};
      S_A7: tag_cmd = '{1'b1, 1'b1, cs + aux - addr_t'(4), DATA_W'(aux)};
      S_AM0: tag_cmd = '{1'b1, 1'b1, c + addr_t'(4), USED_MARK};
      S_AM1: tag_cmd = '{1'b1, 1'b1, cs - addr_t'(8), USED_MARK};
      S_G2: tag_cmd = '{1'b1, 1'b1, used, DATA_W'(sz)};
      S_G3: tag_cmd = '{1'b1, 1'b1, cs - addr_t'(4), DATA_W'(s)};
      S_F0: if (!f0_bad) tag_cmd = '{1'b1, 1'b0, f0_c, '0};
      S_F1: if (size_ok(tag_rdata, used - c)) tag_cmd = '{1'b1, 1'b0, c + addr_t'(4), '0};
      S_F2: if (rd_used) tag_cmd = '{1'b1, 1'b0, cs - addr_t'(8), '0};
      S_F3: if (rd_used) tag_cmd = '{1'b1, 1'b0, cs - addr_t'(4), '0};
      S_F4: begin
        if (tag_rdata == DATA_W'(s) && c != '0) tag_cmd = '{1'b1, 1'b0, c - addr_t'(4), '0};
      end
      S_FL1: begin
        if (size_ok(tag_rdata, c)) tag_cmd = '{1'b1, 1'b0, c - addr_t'(tag_rdata), '0};
      end
      S_FL2: begin
        if (tag_rdata == DATA_W'(aux)) tag_cmd = '{1'b1, 1'b0, c - aux + addr_t'(4), '0};
      end
      S_FL4: tag_cmd = '{1'b1, 1'b1, c - aux, DATA_W'(s + aux)};
      S_FL5: tag_cmd = '{1'b1, 1'b1, cs - addr_t'(4), DATA_W'(s)};
      S_FR0: if (cs < used) tag_cmd = '{1'b1, 1'b0, cs, '0};
      S_FR1: if (size_ok(tag_rdata, used - cs)) tag_cmd = '{1'b1, 1'b0, cs + addr_t'(4), '0};
      S_FR3: tag_cmd = '{1'b1, 1'b1, c, DATA_W'(s + aux)};
      S_FR4: tag_cmd = '{1'b1, 1'b1, cs - addr_t'(4), DATA_W'(s)};
      S_UL0: tag_cmd = '{1'b1, 1'b0, ax + asz - addr_t'(8), '0};
      S_UL1: tag_cmd = '{1'b1, 1'b0, ax + addr_t'(4), '0};
      S_UL2: begin
        if (prv != '0) tag_cmd = '{1'b1, 1'b1, chunk_of(DATA_W'(prv)) + addr_t'(4), tag_rdata};
        else           bin_cmd = '{1'b1, bin_of(asz), tag_rdata[LINK_W-1:0]};
      end
      S_SP0: tag_cmd = '{1'b1, 1'b0, sp_chunk, '0};
      S_SP1: tag_cmd = '{1'b1, 1'b1, sp_chunk + addr_t'(tag_rdata) - addr_t'(8), DATA_W'(sp_val)};
      S_IN0: tag_cmd = '{1'b1, 1'b1, ax + asz - addr_t'(8), '0};
      S_IN1: begin
        tag_cmd = '{1'b1, 1'b1, ax + addr_t'(4), DATA_W'(head)};
        bin_cmd = '{1'b1, bi, link_of(ax)};
      end
      S_RESULT: done = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      used  <= '0;
      spare <= '0;
      top   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      case (state)
        S_G1: begin
          if (!grow_fail) begin
            spare <= spare + aux;
            top   <= top + aux;
          end
        end
        S_G2: begin
          spare <= spare - sz;
          used  <= used + sz;
        end
        S_FIN: begin
          if (fin_tail) begin
            used  <= c;
            spare <= top - c;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          p_q        <= payload_offset;
          sz         <= (addr_t'(request_size) + addr_t'(TAG_OVERHEAD + 7)) & ~addr_t'(7);
          res_offset <= '0;
          res_status <= 1'b0;
        end
      end
      S_A0:  bi <= avail_idx;
      S_A1:  c <= chunk_of(DATA_W'(head));
      S_A2: begin
        sp_chunk <= chunk_of(tag_rdata);
        sp_val   <= '0;
      end
      S_A4: begin
        if (split) begin
          aux <= left;
          s   <= csz;
        end else begin
          s <= addr_t'(tag_rdata);
        end
      end
      S_A7: begin
        ax  <= cs;
        asz <= aux;
      end
      S_AM1: res_offset <= LINK_W'(c + addr_t'(8));
      S_G0:  aux <= grow_need;
      S_G1:  if (grow_fail) res_status <= 1'b1;
      S_G2: begin
        c <= used;
        s <= sz;
      end
      S_F0:  c <= f0_c;
      S_F1:  s <= addr_t'(tag_rdata);
      S_FL1: aux <= addr_t'(tag_rdata);
      S_FL3: begin
        ax  <= c - aux;
        asz <= aux;
      end
      S_FL4: begin
        c <= c - aux;
        s <= s + aux;
      end
      S_FR1: aux <= addr_t'(tag_rdata);
      S_FR2: begin
        ax  <= cs;
        asz <= aux;
      end
      S_FR3: s <= s + aux;
      S_FIN: begin
        ax  <= c;
        asz <= s;
      end
      S_UL1: prv <= tag_rdata[LINK_W-1:0];
      S_UL2: begin
        sp_chunk <= chunk_of(tag_rdata);
        sp_val   <= prv;
      end
      S_IN0: bi <= bin_of(asz);
      S_IN1: begin
        sp_chunk <= chunk_of(DATA_W'(head));
        sp_val   <= link_of(ax);
      end
      default: ;
    endcase
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE) else $error("word taken while sequencer busy");

  a_arena_balance: assert property (@(posedge clk) disable iff (rst)
    top == used + spare) else $error("arena top differs from used plus spare");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> state == S_IDLE) else $error("sequencer not idle after result");

endmodule

// File: hdl/binned_heap_allocator_unit.sv
// top level of the binned heap allocator: handshakes, limit register, result register
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | in        | in_valid / in_stall    | op, request_size, payload_offset
//  out     | out       | out_valid / out_stall  | result_offset, status
//  cfg     | in        | cfg_wr_en              | cfg_wr_data (heap_limit)
//
//  one word at a time: the sequencer walks the tags through the single-port tag store,
//  and a new word is taken only once the last one has handed on its result.
//  reset empties bins and counters and sets the limit to 65536; the tag store is not cleared.
//  a finished result sits in the output register while the next word is taken;
//  out_stall only holds the sequencer once a second result is ready.
module binned_heap_allocator_unit #(
  parameter int HEAP_BYTES = bha_pkg::DEF_HEAP_BYTES,
  parameter int NUM_BINS   = bha_pkg::DEF_NUM_BINS,
  parameter int PAGE_BYTES = bha_pkg::DEF_PAGE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [15:0]                 request_size,
  input  logic [15:0]                 payload_offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 result_offset,
  output logic                        status,
  input  logic                        cfg_wr_en,
  input  logic [bha_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import bha_pkg::*;

  logic [LIMIT_W-1:0]   heap_limit;
  logic                 start, busy, done, out_free;
  logic [15:0]          res_offset;
  logic                 res_status;
  tag_cmd_t             tag_cmd;
  logic [DATA_W-1:0]    tag_rdata;
  bin_cmd_t             bin_cmd;
  logic [BIN_IDX_W-1:0] head_idx, avail_idx;
  logic [LINK_W-1:0]    head;
  logic [BIN_IDX_W:0]   min_bin;
  logic                 avail_any;

  assign in_stall = busy;
  assign start    = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      heap_limit <= cfg_wr_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result_offset <= res_offset;
      status        <= res_status;
    end
  end

  bha_seq #(
    .HEAP_BYTES(HEAP_BYTES),
    .NUM_BINS  (NUM_BINS),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .op            (op),
    .request_size  (request_size),
    .payload_offset(payload_offset),
    .heap_limit    (heap_limit),
    .out_free      (out_free),
    .busy          (busy),
    .done          (done),
    .res_offset    (res_offset),
    .res_status    (res_status),
    .tag_cmd       (tag_cmd),
    .tag_rdata     (tag_rdata),
    .bin_cmd       (bin_cmd),
    .head_idx      (head_idx),
    .head          (head),
    .min_bin       (min_bin),
    .avail_any     (avail_any),
    .avail_idx     (avail_idx)
  );

  bha_tag_mem #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_tag_mem (
    .clk  (clk),
    .cmd  (tag_cmd),
    .rdata(tag_rdata)
  );

  bha_bins #(
    .NUM_BINS(NUM_BINS)
  ) u_bins (
    .clk      (clk),
    .rst      (rst),
    .cmd      (bin_cmd),
    .head_idx (head_idx),
    .head     (head),
    .min_bin  (min_bin),
    .avail_any(avail_any),
    .avail_idx(avail_idx)
  );

endmodule

// File: tb/tb_binned_heap_allocator_unit.sv
// testbench of the binned heap allocator: mirrored allocator, random traffic, result checks
`timescale 1ns / 100ps

module tb_binned_heap_allocator_unit;

  localparam bit OP_ALLOC = 1'b0;
  localparam bit OP_FREE  = 1'b1;
  localparam bit ST_DONE  = 1'b0;
  localparam bit ST_OOM   = 1'b1;

  localparam int unsigned MARK      = 32'hDEAD_DEAD;
  localparam int unsigned N_BINS    = 17;
  localparam int unsigned PAGE      = 4096;
  localparam int unsigned ARENA     = 65536;
  localparam int unsigned TAG_WORDS = ARENA / 4;
  localparam int          SETTLE    = 40;

  // mirror of the allocator state and the answers still owed by the block
  class heap_mirror;
    typedef struct {
      bit [15:0] offset;
      bit        st;
    } answer_t;

    bit [31:0]   tags[TAG_WORDS];
    int unsigned heads[N_BINS];
    int unsigned bitmap, used, spare, top, limit;
    answer_t     owed[$];
    int unsigned errors, n_alloc, n_oom, n_free;

    function new();
      foreach (tags[i]) tags[i] = '0;
      foreach (heads[i]) heads[i] = 0;
      bitmap = 0; used = 0; spare = 0; top = 0; limit = 65536;
    endfunction

    function int unsigned rd(int unsigned a);
      return ((a >> 2) < TAG_WORDS) ? tags[a >> 2] : 0;
    endfunction

    function void wr(int unsigned a, int unsigned v);
      if ((a >> 2) < TAG_WORDS) tags[a >> 2] = v;
    endfunction

    function int unsigned top_bit(int unsigned v);
      int unsigned i;
      i = 0;
      while (v > 1) begin
        v >>= 1;
        i++;
      end
      return i;
    endfunction

    function int unsigned bin_for(int unsigned s);
      int unsigned b;
      b = top_bit(s);
      return (b >= N_BINS) ? N_BINS - 1 : b;
    endfunction

    function int unsigned as_link(int unsigned c);
      return (c & 32'hFFF8) | 1;
    endfunction

    function int unsigned from_link(int unsigned l);
      return l & 32'hFFF8;
    endfunction

    function void put_back_link(int unsigned c, int unsigned l);
      wr(c + rd(c) - 8, l);
    endfunction

    function bit fits(int unsigned s, int unsigned room);
      return s >= 16 && (s & 7) == 0 && s <= room;
    endfunction

    function void stamp_size(int unsigned c, int unsigned s);
      wr(c, s);
      wr(c + s - 4, s);
    endfunction

    function void bin_push(int unsigned c);
      int unsigned bi;
      bi = bin_for(rd(c));
      put_back_link(c, 0);
      wr(c + 4, heads[bi]);
      if (heads[bi] != 0) put_back_link(from_link(heads[bi]), as_link(c));
      heads[bi] = as_link(c);
      bitmap |= 1 << bi;
    endfunction

    function void bin_remove(int unsigned c);
      int unsigned s, pv, nx, bi;
      s = rd(c);
      pv = rd(c + s - 8);
      nx = rd(c + 4);
      if (pv != 0) begin
        wr(from_link(pv) + 4, nx);
        if (nx != 0) put_back_link(from_link(nx), pv);
      end else begin
        bi = bin_for(s);
        if (nx != 0) put_back_link(from_link(nx), 0);
        heads[bi] = nx;
        if (nx == 0) bitmap &= ~(1 << bi);
      end
    endfunction

    // a stale release that is turned away before any tag past the header is read
    function bit stale_rejected(int unsigned p);
      int unsigned c;
      c = p - 8;
      if (c >= used) return 1;
      if (!fits(rd(c), used - c)) return 1;
      return rd(c + 4) != MARK;
    endfunction

    // allocation: lowest usable bin with optional split, else carve from spare space
    function int unsigned take(int unsigned req, output bit st);
      int unsigned sz, minbin, avail, c, bi, bsize, left, csz, grow;
      st = ST_DONE;
      sz = (req + 16 + 7) & ~32'd7;
      minbin = top_bit(sz - 1) + 1;
      avail = bitmap & 32'h1FFFF & ~((1 << minbin) - 1);
      if (avail != 0) begin
        bi = 0;
        while (((avail >> bi) & 1) == 0) bi++;
        c = from_link(heads[bi]);
        heads[bi] = rd(c + 4);
        if (heads[bi] == 0) bitmap &= ~(1 << bi);
        else put_back_link(from_link(heads[bi]), 0);
        bsize = 1 << bi;
        if (bsize >= sz && bsize - sz >= 16) begin
          left = bsize - sz;
          csz = rd(c) - left;
          stamp_size(c, csz);
          stamp_size(c + csz, left);
          bin_push(c + csz);
        end
        wr(c + 4, MARK);
        wr(c + rd(c) - 8, MARK);
        return c + 8;
      end
      if (spare < sz) begin
        grow = ((sz - spare + PAGE - 1) / PAGE) * PAGE;
        if (used + spare + grow >= limit || top + grow > ARENA) begin
          st = ST_OOM;
          return 0;
        end
        spare += grow;
        top += grow;
      end
      c = used;
      spare -= sz;
      used += sz;
      stamp_size(c, sz);
      wr(c + 4, MARK);
      wr(c + sz - 8, MARK);
      return c + 8;
    endfunction

    // release: checks, merges with free neighbours, back to spare space or a bin
    function void give_back(int unsigned p);
      int unsigned c, s, ts, n, r, ns;
      if (p == 0 || (p & 7) != 0 || p < 8) return;
      c = p - 8;
      if (c >= used) return;
      s = rd(c);
      if (!fits(s, used - c)) return;
      if (rd(c + 4) != MARK) return;
      if (rd(c + s - 8) != MARK || rd(c + s - 4) != s) return;
      if (c != 0) begin
        ts = rd(c - 4);
        if (fits(ts, c)) begin
          if (rd(c - ts) == ts && rd(c - ts + 4) != MARK) begin
            n = c - ts;
            bin_remove(n);
            c = n;
            s += ts;
            stamp_size(c, s);
          end
        end
      end
      if (c + s < used) begin
        r = c + s;
        ns = rd(r);
        if (fits(ns, used - r)) begin
          if (rd(r + 4) != MARK) begin
            bin_remove(r);
            s += ns;
            stamp_size(c, s);
          end
        end
      end
      if (c + s >= used) begin
        used = c;
        spare = top - c;
        return;
      end
      bin_push(c);
    endfunction

    // note an accepted word, return the expected offset
    function bit [15:0] note_request(bit o, bit [15:0] rs, bit [15:0] po);
      answer_t a;
      bit st;
      a.offset = 0;
      a.st = ST_DONE;
      if (o == OP_ALLOC) begin
        a.offset = 16'(take(rs, st));
        a.st = st;
        n_alloc++;
        if (st == ST_OOM) n_oom++;
      end else begin
        give_back(po);
        n_free++;
      end
      owed.push_back(a);
      return a.offset;
    endfunction

    function void check_answer(bit [15:0] off, bit st);
      answer_t a;
      if (owed.size() == 0) begin
        $error("result word with nothing outstanding: offset %0d status %0d", off, st);
        errors++;
        return;
      end
      a = owed.pop_front();
      if (off !== a.offset) begin
        $error("result_offset expected %0d got %0d", a.offset, off);
        errors++;
      end
      if (st !== a.st) begin
        $error("status expected %0d got %0d", a.st, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_ALLOC;
  logic [15:0] request_size = '0;
  logic [15:0] payload_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] result_offset;
  logic        status;
  logic        cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;

  heap_mirror  mirror = new();
  bit [15:0]   live[$];
  bit [15:0]   released[$];
  bit          offering = 1'b0;
  int          burst_left = 0;

  binned_heap_allocator_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .request_size(request_size), .payload_offset(payload_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_offset(result_offset), .status(status),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) mirror.check_answer(result_offset, status);
  end

  // receiver: one early long hold, then a mix of free flow, random and solid stalls
  initial begin
    int mode, len, pct;
    @(negedge rst);
    repeat (300) @(posedge clk);
    out_stall <= 1'b1;
    repeat (400) @(posedge clk);
    forever begin
      mode = $urandom_range(9);
      len = $urandom_range(1, 60);
      pct = (mode < 6) ? 50 : 20;
      if (mode == 9) len = 200;
      repeat (len) begin
        if (mode < 4) out_stall <= 1'b0;
        else if (mode < 8) out_stall <= ($urandom_range(99) < pct);
        else out_stall <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one word, wait for it to be taken, then maybe leave a gap
  task automatic send_word(bit o, bit [15:0] rs, bit [15:0] po, output bit [15:0] off);
    int gap;
    in_valid <= 1'b1;
    op <= o;
    request_size <= rs;
    payload_offset <= po;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    off = mirror.note_request(o, rs, po);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(0, 20);
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic alloc_word(bit [15:0] rs, output bit [15:0] off);
    send_word(OP_ALLOC, rs, 16'($urandom), off);
    if (off != 0) live.push_back(off);
  endtask

  task automatic free_word(bit [15:0] po);
    bit [15:0] dummy;
    send_word(OP_FREE, 16'($urandom), po, dummy);
  endtask

  task automatic free_live(int idx);
    bit [15:0] p;
    p = live[idx];
    live.delete(idx);
    released.push_back(p);
    if (released.size() > 16) void'(released.pop_front());
    free_word(p);
  endtask

  // idle until every owed answer is back, then let the block settle
  task automatic drain();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    while (mirror.owed.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit(bit [16:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror.limit = v;
    @(posedge clk);
  endtask

  task automatic random_words(int n);
    int r, k;
    bit [15:0] off, po;
    int unsigned base;
    repeat (n) begin
      r = $urandom_range(99);
      if (live.size() == 0 || r < 50) begin
        k = $urandom_range(99);
        if (k < 70) alloc_word(16'($urandom_range(0, 120)), off);
        else if (k < 92) alloc_word(16'($urandom_range(0, 1500)), off);
        else if (k < 98) alloc_word(16'($urandom_range(0, 6000)), off);
        else alloc_word(16'($urandom), off);
      end else if (r < 88) begin
        free_live($urandom_range(0, live.size() - 1));
      end else if (r < 91) begin
        free_word(16'd0);
      end else if (r < 94) begin
        po = 16'($urandom);
        po[2:0] = 3'($urandom_range(1, 7));
        free_word(po);
      end else if (r < 97) begin
        base = mirror.used + 8;
        if (base > 65528) base = 65528;
        free_word(16'(base + 8 * $urandom_range(0, (65528 - base) / 8)));
      end else if (released.size() > 0) begin
        // release of a chunk that is already free or reused
        po = released[$urandom_range(0, released.size() - 1)];
        k = -1;
        foreach (live[i]) if (live[i] == po) k = i;
        if (k >= 0) free_live(k);
        else if (mirror.stale_rejected(po)) free_word(po);
        else free_word(16'd0);
      end else begin
        free_word(16'd0);
      end
    end
  endtask

  initial begin
    bit [15:0] a1, a2, a3, a4, b1, b2, x;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_limit(17'd65536);

    // directed: size extremes, both merges, return to spare, bin reuse with split
    alloc_word(16'd0, a1);
    alloc_word(16'd1, x);
    alloc_word(16'hFFFF, x);
    alloc_word(16'd40, a2);
    alloc_word(16'd200, a3);
    alloc_word(16'd8, a4);
    live.delete();
    free_word(a2);
    free_word(a1);
    free_word(a3);
    free_word(16'd0);
    free_word(16'd3);
    free_word(16'hFFF8);
    free_word(a2);
    free_word(a4);
    alloc_word(16'd500, b1);
    alloc_word(16'd500, b2);
    alloc_word(16'd30, x);
    free_live(0);
    alloc_word(16'd10, x);
    alloc_word(16'd100, x);
    alloc_word(16'd61000, x);
    alloc_word(16'd40000, x);
    drain();

    // random phases under a range of limits, extremes included
    random_words(200);
    drain();
    set_limit(17'd12288);
    random_words(130);
    drain();
    set_limit(17'd0);
    random_words(110);
    drain();
    set_limit(17'd4096);
    random_words(110);
    drain();
    set_limit(17'd65535);
    random_words(130);
    drain();
    set_limit(17'h1FFFF);
    random_words(130);
    drain();
    set_limit(17'd65536);
    random_words(120);
    drain();

    $display("covered %0d allocations (%0d out of memory) and %0d releases",
             mirror.n_alloc, mirror.n_oom, mirror.n_free);
    $display("limits from zero to the top of the register, with long output holds");
    if (mirror.errors == 0 && mirror.owed.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
